/* src/ctsb_pkg.sv */
// Shared types and constants for the countdown timer slot bank.
// Used by the timer memory, the slot table, the sequencer and the top level.
`default_nettype none

package ctsb_pkg;

  localparam int HANDLE_W = 4;
  localparam int TICKS_W  = 16;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  // One timer entry as stored in the timer memory
  typedef struct packed {
    logic [TICKS_W-1:0] remaining;
    logic [TICKS_W-1:0] start_value;
    logic               active;
  } timer_entry_t;

  // Operation on the slot table at the selected slot
  typedef struct packed {
    logic                rd;     // read the slot owner (data next cycle)
    logic                set;    // mark slot used and write its owner
    logic                clr;    // free the slot
    logic [HANDLE_W-1:0] owner;  // owner written on set
  } slot_op_t;

endpackage

`default_nettype wire

/* src/ctsb_timer_mem.sv */
// Per-handle timer memory: remaining count, start value and active flag.
// Synchronous read, data valid the cycle after rd_en; entries never written read as zero.
// Depends on ctsb_pkg.
`default_nettype none

module ctsb_timer_mem #(
  parameter int HANDLE_COUNT = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            rd_en,
  input  wire logic [((HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1)-1:0] rd_addr,
  output ctsb_pkg::timer_entry_t               rd_data,
  input  wire logic                            wr_en,
  input  wire logic [((HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1)-1:0] wr_addr,
  input  wire ctsb_pkg::timer_entry_t          wr_data
);
  import ctsb_pkg::*;

  timer_entry_t            mem [HANDLE_COUNT];
  timer_entry_t            rd_q;
  logic [HANDLE_COUNT-1:0] filled;
  logic                    rd_filled;

  // Write and read the entry array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Track which entries hold written data; unwritten ones read as reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_filled <= filled[rd_addr];
      end
    end
  end

  assign rd_data = rd_filled ? rd_q : '0;

endmodule

`default_nettype wire

/* src/ctsb_slot_table.sv */
// Running-slot table: used flags in flops, slot owners in a small memory.
// Owner read is synchronous, owner valid the cycle after op.rd. Depends on ctsb_pkg.
`default_nettype none

module ctsb_slot_table #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] idx,
  input  wire ctsb_pkg::slot_op_t                            op,
  output logic [SLOT_COUNT-1:0]                              used,
  output logic [ctsb_pkg::HANDLE_W-1:0]                      owner
);
  import ctsb_pkg::*;

  logic [HANDLE_W-1:0] owner_mem [SLOT_COUNT];

  // Write owner on claim, read owner for the sweep
  always_ff @(posedge clk) begin
    if (op.set) begin
      owner_mem[idx] <= op.owner;
    end
    if (op.rd) begin
      owner <= owner_mem[idx];
    end
  end

  // Claim and free slots
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (op.set) begin
      used[idx] <= 1'b1;
    end else if (op.clr) begin
      used[idx] <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* src/ctsb_seq.sv */
// Command sequencer: sweeps the slot table, does read-modify-write on the
// timer memory and holds the result register. Depends on ctsb_pkg.
`default_nettype none

module ctsb_seq #(
  parameter int SLOT_COUNT   = 8,
  parameter int HANDLE_COUNT = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      cmd,
  input  wire logic [ctsb_pkg::HANDLE_W-1:0]   handle,
  input  wire logic [ctsb_pkg::TICKS_W-1:0]    load_ticks,
  // output channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 ok,
  output logic                                 is_elapsed,
  output logic                                 is_running,
  output logic [ctsb_pkg::TICKS_W-1:0]         initial_ticks,
  output logic [ctsb_pkg::TICKS_W-1:0]         ticks_passed,
  // slot table
  output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] slot_idx,
  output ctsb_pkg::slot_op_t                   slot_op,
  input  wire logic [SLOT_COUNT-1:0]           slot_used,
  input  wire logic [ctsb_pkg::HANDLE_W-1:0]   slot_owner,
  // timer memory
  output logic                                 tm_rd_en,
  output logic [((HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1)-1:0] tm_rd_addr,
  input  wire ctsb_pkg::timer_entry_t          tm_rd_data,
  output logic                                 tm_wr_en,
  output logic [((HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1)-1:0] tm_wr_addr,
  output ctsb_pkg::timer_entry_t               tm_wr_data
);
  import ctsb_pkg::*;

  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int HIDX_W = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_TICK_SCAN = 11'b00000000010,
    S_TICK_OWN  = 11'b00000000100,
    S_TICK_UPD  = 11'b00000001000,
    S_H_RD      = 11'b00000010000,
    S_H_DATA    = 11'b00000100000,
    S_FREE_SCAN = 11'b00001000000,
    S_STOP_SCAN = 11'b00010000000,
    S_STOP_CMP  = 11'b00100000000,
    S_H_WR      = 11'b01000000000,
    S_OUT       = 11'b10000000000
  } state_t;

  state_t              state;
  cmd_t                cmd_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [TICKS_W-1:0]  load_q;
  logic                hvalid;
  logic                ok_q;
  timer_entry_t        work;
  logic [SIDX_W-1:0]   slot;

  cmd_t                in_cmd;
  logic                slot_last;
  logic                cur_used;
  logic                owner_ok;
  logic                owner_hit;
  logic [TICKS_W-1:0]  dec;
  logic                out_free;

  assign in_cmd    = cmd_t'(cmd);
  assign slot_last = (slot == SIDX_W'(SLOT_COUNT - 1));
  assign cur_used  = slot_used[slot];
  assign owner_ok  = (int'(slot_owner) < HANDLE_COUNT);
  assign owner_hit = (slot_owner == handle_q);
  assign dec       = tm_rd_data.remaining - TICKS_W'(1);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign slot_idx  = slot;

  // Drive slot table and timer memory accesses for the current step
  always_comb begin
    slot_op       = '0;
    slot_op.owner = handle_q;
    tm_rd_en      = 1'b0;
    tm_rd_addr    = HIDX_W'(handle_q);
    tm_wr_en      = 1'b0;
    tm_wr_addr    = HIDX_W'(handle_q);
    tm_wr_data    = work;
    unique case (state)
      S_TICK_SCAN: slot_op.rd = cur_used;
      S_TICK_OWN: begin
        if (owner_ok) begin
          tm_rd_en   = 1'b1;
          tm_rd_addr = HIDX_W'(slot_owner);
        end else begin
          slot_op.clr = 1'b1;
        end
      end
      S_TICK_UPD: begin
        tm_wr_en             = 1'b1;
        tm_wr_addr           = HIDX_W'(slot_owner);
        tm_wr_data           = tm_rd_data;
        tm_wr_data.remaining = dec;
        slot_op.clr          = (dec == '0);
      end
      S_H_RD:      tm_rd_en = 1'b1;
      S_FREE_SCAN: slot_op.set = !cur_used;
      S_STOP_SCAN: slot_op.rd = cur_used;
      S_STOP_CMP:  slot_op.clr = owner_hit;
      S_H_WR:      tm_wr_en = 1'b1;
      default: ;
    endcase
  end

  // Sequence one item at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise the result on completion, drop it once taken
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q    <= in_cmd;
            handle_q <= handle;
            load_q   <= load_ticks;
            hvalid   <= (int'(handle) < HANDLE_COUNT);
            ok_q     <= (in_cmd == CMD_TICK) || (in_cmd == CMD_QUERY);
            work     <= '0;
            slot     <= '0;
            if (in_cmd == CMD_TICK) begin
              state <= S_TICK_SCAN;
            end else if (int'(handle) < HANDLE_COUNT) begin
              state <= S_H_RD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_TICK_SCAN, S_TICK_OWN, S_TICK_UPD: begin
          if ((state == S_TICK_SCAN) && cur_used) begin
            state <= S_TICK_OWN;
          end else if ((state == S_TICK_OWN) && owner_ok) begin
            state <= S_TICK_UPD;
          end else if (slot_last) begin
            state <= hvalid ? S_H_RD : S_OUT;
          end else begin
            slot  <= slot + SIDX_W'(1);
            state <= S_TICK_SCAN;
          end
        end
        S_H_RD: state <= S_H_DATA;
        S_H_DATA: begin
          case (cmd_q)
            CMD_START: begin
              work.remaining   <= load_q;
              work.start_value <= load_q;
              work.active      <= tm_rd_data.active;
              if (tm_rd_data.remaining != '0) begin
                ok_q  <= 1'b1;
                state <= S_H_WR;
              end else begin
                state <= S_FREE_SCAN;
              end
            end
            CMD_STOP: begin
              work  <= '{remaining:   tm_rd_data.remaining,
                         start_value: tm_rd_data.start_value,
                         active:      1'b0};
              state <= S_STOP_SCAN;
            end
            default: begin
              work  <= tm_rd_data;
              state <= S_OUT;
            end
          endcase
        end
        S_FREE_SCAN: begin
          if (!cur_used) begin
            work.active <= 1'b1;
            ok_q        <= 1'b1;
            state       <= S_H_WR;
          end else if (slot_last) begin
            ok_q  <= 1'b0;
            state <= S_H_WR;
          end else begin
            slot <= slot + SIDX_W'(1);
          end
        end
        S_STOP_SCAN: begin
          if (cur_used) begin
            state <= S_STOP_CMP;
          end else if (slot_last) begin
            ok_q  <= 1'b0;
            state <= S_H_WR;
          end else begin
            slot <= slot + SIDX_W'(1);
          end
        end
        S_STOP_CMP: begin
          if (owner_hit) begin
            work.remaining <= '0;
            ok_q           <= 1'b1;
            state          <= S_H_WR;
          end else if (slot_last) begin
            ok_q  <= 1'b0;
            state <= S_H_WR;
          end else begin
            slot  <= slot + SIDX_W'(1);
            state <= S_STOP_SCAN;
          end
        end
        S_H_WR: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Load the result register; invalid handles report zero status
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      ok            <= ok_q;
      is_elapsed    <= hvalid && (work.remaining == '0);
      is_running    <= hvalid && work.active;
      initial_ticks <= hvalid ? work.start_value : '0;
      ticks_passed  <= hvalid ? (work.start_value - work.remaining) : '0;
    end
  end

endmodule

`default_nettype wire

/* src/countdown_timer_slot_bank_core.sv */
// Bank of HANDLE_COUNT count-down timers with SLOT_COUNT running slots. Each item
// is a tick, start, stop or status query and yields one result item with the
// addressed timer's status after the command. Items are handled one at a time;
// the time an item takes is set by the slot sweep of a tick, start or stop:
// in a tick each used slot costs an owner read from the slot memory plus a
// read-modify-write of the timer memory, and a free slot costs only its scan.
// A finished result waits in an output register while the next item is taken.
// Depends on ctsb_pkg, ctsb_seq, ctsb_slot_table and ctsb_timer_mem.
`default_nettype none

module countdown_timer_slot_bank_core #(
  parameter int SLOT_COUNT   = 8,
  parameter int HANDLE_COUNT = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    cmd,
  input  wire logic [ctsb_pkg::HANDLE_W-1:0] handle,
  input  wire logic [ctsb_pkg::TICKS_W-1:0]  load_ticks,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               ok,
  output logic                               is_elapsed,
  output logic                               is_running,
  output logic [ctsb_pkg::TICKS_W-1:0]       initial_ticks,
  output logic [ctsb_pkg::TICKS_W-1:0]       ticks_passed
);
  import ctsb_pkg::*;

  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int HIDX_W = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;

  logic [SIDX_W-1:0]     slot_idx;
  slot_op_t              slot_op;
  logic [SLOT_COUNT-1:0] slot_used;
  logic [HANDLE_W-1:0]   slot_owner;
  logic                  tm_rd_en;
  logic [HIDX_W-1:0]     tm_rd_addr;
  timer_entry_t          tm_rd_data;
  logic                  tm_wr_en;
  logic [HIDX_W-1:0]     tm_wr_addr;
  timer_entry_t          tm_wr_data;

  ctsb_seq #(
    .SLOT_COUNT  (SLOT_COUNT),
    .HANDLE_COUNT(HANDLE_COUNT)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .handle       (handle),
    .load_ticks   (load_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .is_elapsed   (is_elapsed),
    .is_running   (is_running),
    .initial_ticks(initial_ticks),
    .ticks_passed (ticks_passed),
    .slot_idx     (slot_idx),
    .slot_op      (slot_op),
    .slot_used    (slot_used),
    .slot_owner   (slot_owner),
    .tm_rd_en     (tm_rd_en),
    .tm_rd_addr   (tm_rd_addr),
    .tm_rd_data   (tm_rd_data),
    .tm_wr_en     (tm_wr_en),
    .tm_wr_addr   (tm_wr_addr),
    .tm_wr_data   (tm_wr_data)
  );

  ctsb_slot_table #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slots (
    .clk  (clk),
    .rst  (rst),
    .idx  (slot_idx),
    .op   (slot_op),
    .used (slot_used),
    .owner(slot_owner)
  );

  ctsb_timer_mem #(
    .HANDLE_COUNT(HANDLE_COUNT)
  ) u_timers (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (tm_rd_en),
    .rd_addr(tm_rd_addr),
    .rd_data(tm_rd_data),
    .wr_en  (tm_wr_en),
    .wr_addr(tm_wr_addr),
    .wr_data(tm_wr_data)
  );

`ifndef SYNTHESIS
  // No state changes while waiting for an item
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(slot_op.set || slot_op.clr || tm_wr_en))
    else $error("state written while idle");

  // A start claims only a free slot
  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    slot_op.set |-> !slot_used[slot_idx])
    else $error("claimed a used slot");

  // A claimed slot is followed by the timer entry write-back
  a_claim_wb: assert property (@(posedge clk) disable iff (rst)
    slot_op.set |=> tm_wr_en)
    else $error("slot claim without timer write-back");

  // An elapsed timer reports its whole start value as passed
  a_elapsed: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_elapsed |-> ticks_passed == initial_ticks)
    else $error("elapsed status inconsistent");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for countdown_timer_slot_bank_core: a directed table, then random items.
// Each accepted item runs through a timer and slot model; result items are compared in order.
// Depends on ctsb_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  import ctsb_pkg::*;

  localparam int SLOTS        = 8;
  localparam int HANDLES      = 16;
  localparam int RANDOM_ITEMS = 1550;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;

  // Status fields of one result item
  typedef struct packed {
    logic               ok;
    logic               elapsed;
    logic               running;
    logic [TICKS_W-1:0] init;
    logic [TICKS_W-1:0] passed;
  } timer_status_t;

  // One directed item, with its status typed in where it is obvious
  typedef struct packed {
    cmd_t                cmd;
    logic [HANDLE_W-1:0] hnd;
    logic [TICKS_W-1:0]  load;
    logic                typed;
    timer_status_t       status;
  } table_row_t;

  localparam timer_status_t NO_STATUS = '0;

  localparam table_row_t DIRECTED [25] = '{
    '{CMD_QUERY, 4'd0,  16'h0000, 1'b1, '{1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000}},
    '{CMD_TICK,  4'd15, 16'hFFFF, 1'b1, '{1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000}},
    '{CMD_STOP,  4'd3,  16'h0000, 1'b1, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}},
    '{CMD_START, 4'd1,  16'hFFFF, 1'b1, '{1'b1, 1'b0, 1'b1, 16'hFFFF, 16'h0000}},
    '{CMD_START, 4'd2,  16'h0000, 1'b1, '{1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000}},
    '{CMD_TICK,  4'd2,  16'h1234, 1'b0, NO_STATUS},
    '{CMD_START, 4'd5,  16'h0000, 1'b1, '{1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000}},
    '{CMD_START, 4'd5,  16'h0003, 1'b1, '{1'b1, 1'b0, 1'b1, 16'h0003, 16'h0000}},
    '{CMD_TICK,  4'd5,  16'h0000, 1'b0, NO_STATUS},
    '{CMD_START, 4'd7,  16'h0001, 1'b0, NO_STATUS},
    '{CMD_TICK,  4'd7,  16'h0000, 1'b0, NO_STATUS},
    '{CMD_STOP,  4'd7,  16'h0000, 1'b0, NO_STATUS},
    '{CMD_START, 4'd8,  16'h8000, 1'b0, NO_STATUS},
    '{CMD_START, 4'd9,  16'h5555, 1'b0, NO_STATUS},
    '{CMD_START, 4'd10, 16'hAAAA, 1'b0, NO_STATUS},
    '{CMD_START, 4'd11, 16'h7FFF, 1'b0, NO_STATUS},
    '{CMD_START, 4'd13, 16'h00FF, 1'b0, NO_STATUS},
    '{CMD_START, 4'd12, 16'h0100, 1'b0, NO_STATUS},
    '{CMD_STOP,  4'd12, 16'h0000, 1'b0, NO_STATUS},
    '{CMD_STOP,  4'd1,  16'h0000, 1'b0, NO_STATUS},
    '{CMD_START, 4'd12, 16'h0010, 1'b0, NO_STATUS},
    '{CMD_STOP,  4'd5,  16'h0000, 1'b0, NO_STATUS},
    '{CMD_QUERY, 4'd12, 16'h0000, 1'b0, NO_STATUS},
    '{CMD_START, 4'd15, 16'hFFFF, 1'b0, NO_STATUS},
    '{CMD_QUERY, 4'd15, 16'h0000, 1'b0, NO_STATUS}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          cmd;
  logic [HANDLE_W-1:0] handle;
  logic [TICKS_W-1:0]  load_ticks;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                ok;
  logic                is_elapsed;
  logic                is_running;
  logic [TICKS_W-1:0]  initial_ticks;
  logic [TICKS_W-1:0]  ticks_passed;

  // Model of the timer bank; counts and start values begin at zero
  bit                  slot_used [SLOTS];
  logic [HANDLE_W-1:0] slot_owner [SLOTS];
  bit [TICKS_W-1:0]    remaining_cnt [HANDLES];
  bit [TICKS_W-1:0]    start_val [HANDLES];
  bit                  timer_active [HANDLES];

  timer_status_t pending_status_q [$];
  int fail_count   = 0;
  int results_seen = 0;
  int expiries     = 0;
  int refused      = 0;
  int cmd_count [4] = '{0, 0, 0, 0};
  int burst_left   = 0;
  int cycle_count  = 0;

  countdown_timer_slot_bank_core #(
    .SLOT_COUNT   (SLOTS),
    .HANDLE_COUNT (HANDLES)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .handle        (handle),
    .load_ticks    (load_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ok            (ok),
    .is_elapsed    (is_elapsed),
    .is_running    (is_running),
    .initial_ticks (initial_ticks),
    .ticks_passed  (ticks_passed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one command to the model and return the addressed timer's status
  function automatic timer_status_t run_timer_cmd(cmd_t c, logic [HANDLE_W-1:0] h,
                                                  logic [TICKS_W-1:0] load);
    timer_status_t st;
    bit            in_range;
    bit            done;
    int            owner;
    in_range = (int'(h) < HANDLES);
    st       = '0;
    st.ok    = 1'b1;
    done     = 1'b0;
    case (c)
      // Sweep the slots in order; free a slot whose owner reaches zero
      CMD_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_used[s]) begin
            owner = int'(slot_owner[s]);
            if (owner >= HANDLES) begin
              slot_used[s] = 1'b0;
            end else begin
              remaining_cnt[owner] = remaining_cnt[owner] - 1'b1;
              if (remaining_cnt[owner] == '0) begin
                slot_used[s] = 1'b0;
                expiries++;
              end
            end
          end
        end
      end
      // Load the count; a counting timer just restarts, else grab the lowest free slot
      CMD_START: begin
        if (!in_range) begin
          st.ok = 1'b0;
        end else begin
          done             = (remaining_cnt[h] != '0);
          start_val[h]     = load;
          remaining_cnt[h] = load;
          for (int s = 0; s < SLOTS; s++) begin
            if (!done && !slot_used[s]) begin
              slot_used[s]    = 1'b1;
              slot_owner[s]   = h;
              timer_active[h] = 1'b1;
              done            = 1'b1;
            end
          end
          st.ok = done;
        end
      end
      // Drop the active flag; release the lowest slot owned by the handle and zero its count
      CMD_STOP: begin
        if (!in_range) begin
          st.ok = 1'b0;
        end else begin
          timer_active[h] = 1'b0;
          for (int s = 0; s < SLOTS; s++) begin
            if (!done && slot_used[s] && slot_owner[s] == h) begin
              slot_used[s]     = 1'b0;
              remaining_cnt[h] = '0;
              done             = 1'b1;
            end
          end
          st.ok = done;
        end
      end
      default: ;
    endcase
    if (in_range) begin
      st.elapsed = (remaining_cnt[h] == '0);
      st.running = timer_active[h];
      st.init    = start_val[h];
      st.passed  = start_val[h] - remaining_cnt[h];
    end
    return st;
  endfunction

  function automatic void check_field(string name, logic [TICKS_W-1:0] want,
                                      logic [TICKS_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one item in bursts with gaps, wait for it to be taken, queue its status
  task automatic send_item(cmd_t c, logic [HANDLE_W-1:0] h, logic [TICKS_W-1:0] load,
                           bit typed, timer_status_t typed_status);
    timer_status_t st;
    int            gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    handle     <= h;
    load_ticks <= load;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    st = run_timer_cmd(c, h, load);
    pending_status_q.push_back(typed ? typed_status : st);
    cmd_count[int'(c)]++;
    if (!st.ok) refused++;
  endtask

  // Receiver back-pressure: switch between free flow, light, heavy and periodic stalls
  int stall_left  = 0;
  int stall_mode  = 0;
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((stall_phase % 7) < 3);
      endcase
    end
  end

  // Compare each taken result item with the oldest pending status
  always @(posedge clk) begin
    timer_status_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_status_q.size() == 0) begin
        $error("result item with no pending expectation");
        fail_count++;
      end else begin
        want = pending_status_q.pop_front();
        check_field("ok", want.ok, ok);
        check_field("is_elapsed", want.elapsed, is_elapsed);
        check_field("is_running", want.running, is_running);
        check_field("initial_ticks", want.init, initial_ticks);
        check_field("ticks_passed", want.passed, ticks_passed);
      end
    end
  end

  // Hang guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset, directed table, random items, drain, verdict
  initial begin
    int                  pick;
    cmd_t                c;
    logic [HANDLE_W-1:0] h;
    logic [TICKS_W-1:0]  load;
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = CMD_TICK;
    handle     = '0;
    load_ticks = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(DIRECTED); r++) begin
      send_item(DIRECTED[r].cmd, DIRECTED[r].hnd, DIRECTED[r].load,
                DIRECTED[r].typed, DIRECTED[r].status);
    end

    // Mostly ticks and starts with short counts so slots fill, expire and recycle
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) c = CMD_TICK;
      else if (pick < 70) c = CMD_START;
      else if (pick < 85) c = CMD_STOP;
      else c = CMD_QUERY;
      h    = HANDLE_W'($urandom_range(0, HANDLES - 1));
      pick = $urandom_range(0, 99);
      if (pick < 50) load = TICKS_W'($urandom_range(1, 6));
      else if (pick < 65) load = '0;
      else if (pick < 85) load = TICKS_W'($urandom);
      else load = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h8000;
      send_item(c, h, load, 1'b0, NO_STATUS);
    end
    in_valid <= 1'b0;

    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks, %0d starts, %0d stops, %0d queries; %0d starts/stops refused",
             cmd_count[int'(CMD_TICK)], cmd_count[int'(CMD_START)],
             cmd_count[int'(CMD_STOP)], cmd_count[int'(CMD_QUERY)], refused);
    $display("%0d slots freed on expiry, %0d result items compared", expiries, results_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ctsb_pkg.sv
src/ctsb_timer_mem.sv
src/ctsb_slot_table.sv
src/ctsb_seq.sv
src/countdown_timer_slot_bank_core.sv
tb/tb_top.sv
